>>> src/nms_pkg.sv
// Package: register indexes, reset values and field widths for the 3x3 NMS block.
`timescale 1ns / 1ps

package nms_pkg;

   localparam int THR_BITS  = 16;   // threshold register and response field
   localparam int DIM_BITS  = 11;   // image width and height registers
   localparam int CSR_BITS  = 16;   // widest register
   localparam int IDX_BITS  = 2;

   typedef enum logic [IDX_BITS-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // 200.0 in 8.8
   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(200 * 256);
   localparam logic [DIM_BITS-1:0] WIDTH_RESET     = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET    = DIM_BITS'(480);

endpackage

>>> src/nms_3x3_threshold.sv
// Streaming 3x3 non-maximum suppression with threshold over a raster of 8.8 responses.
//
//   channel | direction | ports                                        | meaning
//   req     | in        | req_valid/req_stall, req_response, req_flush | pixel or drain request
//   rsp     | out       | rsp_valid/rsp_stall, rsp_is_corner,          | zero or one result
//           |           | rsp_frame_last                               | per request
//   csr     | in        | csr_write, csr_index, csr_data               | register write, no wait
//
// One request per cycle sustained while no due result is held by rsp_stall. A request is
// registered with its line-store read when accepted, then judged, and its result is
// registered in the output register that drives rsp_valid. The line store is one
// read and one write port memory.
// Reset is synchronous; no clearing pass, stale line entries fall outside the image.
// req_stall rises only when a result is due while the output register is held by rsp_stall.
`timescale 1ns / 1ps

module nms_3x3_threshold #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nms_pkg::THR_BITS-1:0]  req_response,
   input  logic                          req_flush,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_corner,
   output logic                          rsp_frame_last,
   input  logic                          csr_write,
   input  logic [nms_pkg::IDX_BITS-1:0]  csr_index,
   input  logic [nms_pkg::CSR_BITS-1:0]  csr_data
);
   import nms_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WB = CW + 1;
   localparam int HB = $clog2(MAX_HEIGHT) + 1;
   localparam int PB = (VALUE_BITS < THR_BITS) ? VALUE_BITS : THR_BITS;

   typedef struct packed {
      logic emit;
      logic last;
      logic no_up;
      logic no_down;
      logic no_left;
      logic no_right;
   } judge_ctl_type;

   // registers
   logic [THR_BITS-1:0] threshold_ff;
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   logic [CW-1:0]       col_ff;
   logic [HB-1:0]       row_ff;
   logic                s1_valid_ff;
   logic [PB-1:0]       s1_pix_ff;
   logic [CW-1:0]       s1_col_ff;
   judge_ctl_type       s1_ctl_ff;
   logic                byp_ff;
   logic [2*PB-1:0]     byp_data_ff;
   logic [2*PB-1:0]     line_rd_ff;
   logic [PB-1:0]       win_ff [3][3];
   logic                rsp_valid_ff;
   logic                rsp_is_corner_ff;
   logic                rsp_frame_last_ff;

   // line store: upper half is two rows back, lower half one row back
   logic [2*PB-1:0]     line_mem [MAX_WIDTH];

   logic [WB-1:0]       w_cur;
   logic [HB-1:0]       h_cur;
   logic                accept;
   logic                first_col;
   logic                emit_a;
   logic [HB-1:0]       orow;
   logic [CW-1:0]       ocol;
   logic [WB-1:0]       col_inc;
   logic [PB-1:0]       pix_in;
   judge_ctl_type       ctl_in;
   logic [CW-1:0]       col_in;
   logic [HB-1:0]       row_in;
   logic                restart;

   logic [2*PB-1:0]     line_word;
   logic [PB-1:0]       s1_top;
   logic [PB-1:0]       s1_mid;
   logic [PB-1:0]       nwin [3][3];
   logic                bigger;
   logic                corner;
   logic                s1_go;

   // geometry, zero acts as one and oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         w_cur = WB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_cur = WB'(MAX_WIDTH);
      end else begin
         w_cur = WB'(width_ff);
      end
      if (height_ff == '0) begin
         h_cur = HB'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_cur = HB'(MAX_HEIGHT);
      end else begin
         h_cur = HB'(height_ff);
      end
   end

   // front end: position, output coordinates and border flags
   always_comb begin
      first_col = (col_ff == '0);
      emit_a    = first_col && (row_ff >= HB'(2));
      ctl_in.emit = emit_a || (!first_col && (row_ff != '0));
      orow = emit_a ? (row_ff - HB'(2)) : (row_ff - HB'(1));
      ocol = emit_a ? CW'(w_cur - WB'(1)) : (col_ff - CW'(1));
      ctl_in.no_up    = (orow == '0);
      ctl_in.no_down  = ((orow + HB'(1)) >= h_cur);
      ctl_in.no_left  = (ocol == '0);
      ctl_in.no_right = ((WB'(ocol) + WB'(1)) >= w_cur);
      ctl_in.last     = ctl_in.emit && ctl_in.no_down && ctl_in.no_right;

      if ((row_ff < h_cur) && !req_flush) begin
         pix_in = PB'(req_response);
      end else begin
         pix_in = '0;
      end

      col_inc = WB'(col_ff) + WB'(1);
      if (ctl_in.last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= w_cur) begin
         col_in = '0;
         row_in = row_ff + HB'(1);
      end else begin
         col_in = CW'(col_inc);
         row_in = row_ff;
      end
   end

   // judge stage: new window column, then 3x3 compare around the centre and threshold test
   always_comb begin
      line_word = byp_ff ? byp_data_ff : line_rd_ff;
      s1_top    = line_word[2*PB-1:PB];
      s1_mid    = line_word[PB-1:0];
      for (int r = 0; r < 3; r++) begin
         nwin[r][0] = win_ff[r][1];
         nwin[r][1] = win_ff[r][2];
      end
      nwin[0][2] = s1_top;
      nwin[1][2] = s1_mid;
      nwin[2][2] = s1_pix_ff;

      bigger = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 0 && s1_ctl_ff.no_up) && !(r == 2 && s1_ctl_ff.no_down) &&
                !(c == 0 && s1_ctl_ff.no_left) && !(c == 2 && s1_ctl_ff.no_right) &&
                (nwin[r][c] > nwin[1][1])) begin
               bigger = 1'b1;
            end
         end
      end
      corner = (THR_BITS'(nwin[1][1]) > threshold_ff) && !bigger;
   end

   assign s1_go     = s1_valid_ff && (!s1_ctl_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;
   assign restart   = csr_write && ((csr_index == CSR_IMAGE_WIDTH) ||
                                    (csr_index == CSR_IMAGE_HEIGHT));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_THRESHOLD:    threshold_ff <= csr_data[THR_BITS-1:0];
               CSR_IMAGE_WIDTH:  width_ff     <= csr_data[DIM_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_ff    <= csr_data[DIM_BITS-1:0];
               default:          ;
            endcase
         end

         if (restart) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end

         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_go && s1_ctl_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (restart) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  win_ff[r][c] <= '0;
               end
            end
         end else if (s1_go) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 3; c++) begin
                  win_ff[r][c] <= nwin[r][c];
               end
            end
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= pix_in;
         s1_col_ff   <= col_ff;
         s1_ctl_ff   <= ctl_in;
         // write from the judge stage lands on the address read this edge (width one)
         byp_ff      <= s1_go && (s1_col_ff == col_ff);
         byp_data_ff <= {s1_mid, s1_pix_ff};
      end
      if (s1_go && s1_ctl_ff.emit) begin
         rsp_is_corner_ff  <= corner;
         rsp_frame_last_ff <= s1_ctl_ff.last;
      end
   end

   // line store, read-before-write
   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_col_ff] <= {s1_mid, s1_pix_ff};
      end
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_corner  = rsp_is_corner_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

>>> src/nms_checker.sv
// Port-level checks for the 3x3 NMS block and the bind that attaches them.
`timescale 1ns / 1ps

module nms_assertions (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_corner,
   input logic rsp_frame_last
);

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_corner) &&
                                 $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // back-pressure only passes through from a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with result side free");

   // a fresh result traces back to an accepted request through the judge stage and output register
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without matching request");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind nms_3x3_threshold nms_assertions u_nms_assertions (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_is_corner  (rsp_is_corner),
   .rsp_frame_last (rsp_frame_last)
);
